FILE: design/mcpid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcpid_pkg: shared constants of the multi-channel PID speed controller
// Field widths, register indexes, reset values and output saturation bounds.
// ----------------------------------------------------------------------------
package mcpid_pkg;

  localparam int CHANNEL_W = 2;
  localparam int SPEED_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam int ERR_W   = SPEED_W + 1;
  localparam int SUM_W   = LIMIT_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int PROD_P_W = GAIN_W + ERR_W;
  localparam int PROD_I_W = GAIN_W + SUM_W;
  localparam int PROD_D_W = GAIN_W + DIFF_W;
  localparam int ACC_W    = PROD_I_W + 2;
  localparam int DRIVE_W  = 29;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 2'd3;

  localparam logic signed [GAIN_W-1:0]  GAIN_P_RESET    = 16'sd512;
  localparam logic signed [GAIN_W-1:0]  GAIN_I_RESET    = 16'sd0;
  localparam logic signed [GAIN_W-1:0]  GAIN_D_RESET    = 16'sd128;
  localparam logic        [LIMIT_W-1:0] INT_LIMIT_RESET = 20'd5000;

  localparam logic signed [ACC_W-1:0] DRIVE_MAX = ACC_W'((64'sd1 <<< (DRIVE_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] DRIVE_MIN = ACC_W'(-(64'sd1 <<< (DRIVE_W - 1)));

endpackage
`default_nettype wire

FILE: design/multi_channel_pid_speed_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_pid_speed_top: per-channel positional PID speed controller
// Keeps a previous error and a saturating error sum for each channel and
// drives (kp*err + ki*sum + kd*(err - last)) >>> fraction bits, saturated.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the output is not stalled and
// returns its drive value through an input register, an error stage that
// reads and updates the channel state, a multiplier stage and an output
// register. Words for the same channel may follow back to back because the
// channel state is updated as a word leaves the error stage. The user must
// write gains only while no word is in flight; the block does not enforce it.
module multi_channel_pid_speed_top #(
  parameter int CHANNELS = 4,
  parameter int GAIN_FRACTION_BITS = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_write,
  input  wire logic [mcpid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [mcpid_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [mcpid_pkg::CHANNEL_W-1:0]         channel,
  input  wire logic signed [mcpid_pkg::SPEED_W-1:0]    measured_speed,
  input  wire logic signed [mcpid_pkg::SPEED_W-1:0]    target_speed,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [mcpid_pkg::DRIVE_W-1:0]         drive_value
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [mcpid_pkg::GAIN_W-1:0] gain_p;
  logic signed [mcpid_pkg::GAIN_W-1:0] gain_i;
  logic signed [mcpid_pkg::GAIN_W-1:0] gain_d;
  logic        [mcpid_pkg::LIMIT_W-1:0] int_limit;

  logic signed [mcpid_pkg::ERR_W-1:0] prev_err [CHANNELS];
  logic signed [mcpid_pkg::SUM_W-1:0] err_sum  [CHANNELS];

  logic                                  s1_valid;
  logic [mcpid_pkg::CHANNEL_W-1:0]       s1_channel;
  logic signed [mcpid_pkg::SPEED_W-1:0]  s1_meas;
  logic signed [mcpid_pkg::SPEED_W-1:0]  s1_targ;

  logic                                  s2_valid;
  logic signed [mcpid_pkg::ERR_W-1:0]    s2_err;
  logic signed [mcpid_pkg::SUM_W-1:0]    s2_sum;
  logic signed [mcpid_pkg::DIFF_W-1:0]   s2_diff;

  logic                                  s3_valid;
  logic signed [mcpid_pkg::PROD_P_W-1:0] s3_prod_p;
  logic signed [mcpid_pkg::PROD_I_W-1:0] s3_prod_i;
  logic signed [mcpid_pkg::PROD_D_W-1:0] s3_prod_d;

  logic out_load;
  logic s3_load;
  logic s2_load;

  logic                                  ch_in_range;
  logic [CH_IDX_W-1:0]                   ch_idx;
  logic signed [mcpid_pkg::ERR_W-1:0]    err_next;
  logic signed [mcpid_pkg::ERR_W-1:0]    prev_err_rd;
  logic signed [mcpid_pkg::SUM_W:0]      sum_raw;
  logic signed [mcpid_pkg::SUM_W:0]      lim_pos;
  logic signed [mcpid_pkg::SUM_W:0]      lim_neg;
  logic signed [mcpid_pkg::SUM_W-1:0]    sum_next;
  logic signed [mcpid_pkg::DIFF_W-1:0]   diff_next;

  logic signed [mcpid_pkg::ACC_W-1:0]    acc;
  logic signed [mcpid_pkg::ACC_W-1:0]    acc_sh;
  logic signed [mcpid_pkg::DRIVE_W-1:0]  drive_next;

  assign out_load = !out_valid || out_ready;
  assign s3_load  = !s3_valid || out_load;
  assign s2_load  = !s2_valid || s3_load;
  assign in_ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= mcpid_pkg::GAIN_P_RESET;
      gain_i    <= mcpid_pkg::GAIN_I_RESET;
      gain_d    <= mcpid_pkg::GAIN_D_RESET;
      int_limit <= mcpid_pkg::INT_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mcpid_pkg::REG_GAIN_P:    gain_p    <= cfg_data[mcpid_pkg::GAIN_W-1:0];
        mcpid_pkg::REG_GAIN_I:    gain_i    <= cfg_data[mcpid_pkg::GAIN_W-1:0];
        mcpid_pkg::REG_GAIN_D:    gain_d    <= cfg_data[mcpid_pkg::GAIN_W-1:0];
        mcpid_pkg::REG_INT_LIMIT: int_limit <= cfg_data[mcpid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_channel <= channel;
      s1_meas    <= measured_speed;
      s1_targ    <= target_speed;
    end
  end

  always_comb begin
    ch_in_range = int'(s1_channel) < CHANNELS;
    ch_idx      = CH_IDX_W'(s1_channel);
    err_next    = mcpid_pkg::ERR_W'(s1_targ) - mcpid_pkg::ERR_W'(s1_meas);
    lim_pos     = $signed({2'b00, int_limit});
    lim_neg     = -lim_pos;
    if (ch_in_range) begin
      prev_err_rd = prev_err[ch_idx];
      sum_raw  = (mcpid_pkg::SUM_W + 1)'(err_sum[ch_idx]) + (mcpid_pkg::SUM_W + 1)'(err_next);
      if (sum_raw > lim_pos) begin
        sum_next = mcpid_pkg::SUM_W'(lim_pos);
      end else if (sum_raw < lim_neg) begin
        sum_next = mcpid_pkg::SUM_W'(lim_neg);
      end else begin
        sum_next = mcpid_pkg::SUM_W'(sum_raw);
      end
    end else begin
      prev_err_rd = '0;
      sum_raw  = '0;
      sum_next = '0;
    end
    diff_next = mcpid_pkg::DIFF_W'(err_next) - mcpid_pkg::DIFF_W'(prev_err_rd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        prev_err[i] <= '0;
        err_sum[i]  <= '0;
      end
    end else begin
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
      if (s2_load && s1_valid && ch_in_range) begin
        prev_err[ch_idx] <= err_next;
        err_sum[ch_idx]  <= sum_next;
      end
    end
    if (s2_load && s1_valid) begin
      s2_err  <= err_next;
      s2_sum  <= sum_next;
      s2_diff <= diff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_load) begin
      s3_valid <= s2_valid;
    end
    if (s3_load && s2_valid) begin
      s3_prod_p <= gain_p * s2_err;
      s3_prod_i <= gain_i * s2_sum;
      s3_prod_d <= gain_d * s2_diff;
    end
  end

  always_comb begin
    acc = mcpid_pkg::ACC_W'(s3_prod_p) + mcpid_pkg::ACC_W'(s3_prod_i)
        + mcpid_pkg::ACC_W'(s3_prod_d);
    acc_sh = acc >>> GAIN_FRACTION_BITS;
    if (acc_sh > mcpid_pkg::DRIVE_MAX) begin
      drive_next = mcpid_pkg::DRIVE_W'(mcpid_pkg::DRIVE_MAX);
    end else if (acc_sh < mcpid_pkg::DRIVE_MIN) begin
      drive_next = mcpid_pkg::DRIVE_W'(mcpid_pkg::DRIVE_MIN);
    end else begin
      drive_next = mcpid_pkg::DRIVE_W'(acc_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s3_valid;
    end
    if (out_load && s3_valid) begin
      drive_value <= drive_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/mcpid_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcpid_checker: port-level checks for the PID speed controller
// Watches the handshake and reset behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module mcpid_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [mcpid_pkg::DRIVE_W-1:0] drive_value
);

  // After reset the pipeline is empty and ready for a word.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // A stalled result word stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_value))
    else $error("result word changed while stalled");

  // With the output register empty, nothing can block the input side.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  // A word accepted with the output empty appears after passing every stage.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid
    |=> out_valid)
    else $error("result word missing after pipeline latency");

endmodule

bind multi_channel_pid_speed_top mcpid_checker u_mcpid_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .drive_value(drive_value)
);
`default_nettype wire
